FILE: rtl/core/keyword_substitution_cipher_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the keyword substitution cipher core
// Each macro checks a property sampled on aclk and switched off in reset.
// ----------------------------------------------------------------------------
`ifndef KEYWORD_SUBSTITUTION_CIPHER_CORE_MACROS_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KSCC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KSCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/kscc_pkg.sv
// ----------------------------------------------------------------------------
// kscc_pkg
// Types and constants shared by the keyword substitution cipher modules.
// ----------------------------------------------------------------------------
package kscc_pkg;

    localparam int unsigned LETTERS    = 26;
    localparam int unsigned IDX_W      = $clog2(LETTERS);
    localparam logic [7:0]  CODE_A     = 8'd65;
    localparam logic [7:0]  CODE_Z     = 8'd90;
    localparam logic [7:0]  CODE_SPACE = 8'd32;
    localparam logic [7:0]  CODE_NONE  = 8'd0;

    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [1:0] {
        FUNC_CLEAR   = 2'd0,
        FUNC_KEY     = 2'd1,
        FUNC_ENCRYPT = 2'd2,
        FUNC_DECRYPT = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_WALK = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    // Append one letter: forward[pos] = letter and inverse[letter] = pos.
    typedef struct packed {
        logic we;
        idx_t pos;
        idx_t letter;
    } tbl_wr_t;

    // Look up one entry of the forward or the inverse table.
    typedef struct packed {
        logic en;
        logic inv;
        idx_t addr;
    } tbl_rd_t;

endpackage

FILE: rtl/core/keyword_substitution_cipher_core.sv
// ----------------------------------------------------------------------------
// keyword_substitution_cipher_core
// Keyword monoalphabetic substitution cipher with an Atbash-style fill.
// ----------------------------------------------------------------------------
// Usage: each slave transfer carries an operation in s_tuser (clear key, key
// letter, encrypt, decrypt) and a character in s_tdata. Every transfer gives
// exactly one master transfer: the transformed letter or a space in m_tdata,
// zero for key operations, and the ignored flag in m_tuser.
// Sequence: the block takes one item at a time, and takes no new item until
// the last has left S_DONE. A clear, a key letter, or a text character once
// the alphabet is complete, goes through S_EXEC and S_DONE, and S_DONE sets
// the registered m_tvalid. The first text character after a key change first
// walks the 26 letters Z down to A through the shared append port, one per
// cycle, in S_WALK, and then returns to S_EXEC for its lookup.
// s_tready is high only while no item is being worked on. A finished result
// waits in the output register; a stalled receiver holds the block in its
// final step until the register is free.
// Reset clears the key, the fill count and the output valid; the tables are
// refilled before any lookup.
// ----------------------------------------------------------------------------
module keyword_substitution_cipher_core
    import kscc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_in
    input  logic [1:0] s_tuser,   // [1:0] func
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] char_out
    output logic [0:0] m_tuser    // [0] ignored
);

    state_t        state_reg, state_next;
    func_t         func_reg, func_next;
    logic [7:0]    char_reg, char_next;
    logic [LETTERS-1:0] used_reg, used_next;
    logic [IDX_W:0] fill_reg, fill_next;
    logic          complete_reg, complete_next;
    idx_t          walk_reg, walk_next;
    logic          ign_reg, ign_next;
    logic          m_valid_reg, m_valid_next;
    logic [7:0]    m_data_reg, m_data_next;
    logic          m_user_reg, m_user_next;

    tbl_wr_t wr;
    tbl_rd_t rd;
    idx_t    rd_data;
    logic    is_upper;
    idx_t    letter;
    idx_t    mapped;
    logic    room;

    kscc_tables u_tables (
        .aclk    (aclk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    assign is_upper = (char_reg >= CODE_A) && (char_reg <= CODE_Z);
    assign letter   = IDX_W'(char_reg - CODE_A);
    assign room     = (fill_reg < (IDX_W+1)'(LETTERS));
    // Table entries are always below 26 once filled; the fold is a safeguard.
    assign mapped   = (rd_data >= IDX_W'(LETTERS)) ? IDX_W'(rd_data - IDX_W'(LETTERS))
                                                   : rd_data;

    always_comb begin
        state_next    = state_reg;
        func_next     = func_reg;
        char_next     = char_reg;
        used_next     = used_reg;
        fill_next     = fill_reg;
        complete_next = complete_reg;
        walk_next     = walk_reg;
        ign_next      = ign_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        wr            = '0;
        rd            = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    func_next  = func_t'(s_tuser);
                    char_next  = s_tdata;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                case (func_reg)
                    FUNC_CLEAR: begin
                        used_next     = '0;
                        fill_next     = '0;
                        complete_next = 1'b0;
                        ign_next      = 1'b0;
                        state_next    = S_DONE;
                    end
                    FUNC_KEY: begin
                        if (complete_reg || !is_upper) begin
                            ign_next = 1'b1;
                        end else begin
                            ign_next = 1'b0;
                            if (!used_reg[letter] && room) begin
                                wr.we             = 1'b1;
                                wr.pos            = fill_reg[IDX_W-1:0];
                                wr.letter         = letter;
                                used_next[letter] = 1'b1;
                                fill_next         = fill_reg + 1'b1;
                            end
                        end
                        state_next = S_DONE;
                    end
                    default: begin
                        ign_next = 1'b0;
                        if (complete_reg) begin
                            rd.en      = 1'b1;
                            rd.inv     = (func_reg == FUNC_DECRYPT);
                            rd.addr    = is_upper ? letter : '0;
                            state_next = S_DONE;
                        end else begin
                            walk_next  = IDX_W'(LETTERS - 1);
                            state_next = S_WALK;
                        end
                    end
                endcase
            end
            S_WALK: begin
                // Unused letters are appended from Z down to A.
                if (!used_reg[walk_reg] && room) begin
                    wr.we               = 1'b1;
                    wr.pos              = fill_reg[IDX_W-1:0];
                    wr.letter           = walk_reg;
                    used_next[walk_reg] = 1'b1;
                    fill_next           = fill_reg + 1'b1;
                end
                if (walk_reg == '0) begin
                    complete_next = 1'b1;
                    state_next    = S_EXEC;
                end else begin
                    walk_next = walk_reg - 1'b1;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_user_next  = ign_reg;
                    if (func_reg == FUNC_CLEAR || func_reg == FUNC_KEY) begin
                        m_data_next = CODE_NONE;
                    end else if (is_upper) begin
                        m_data_next = CODE_A + 8'(mapped);
                    end else begin
                        m_data_next = CODE_SPACE;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            used_reg     <= '0;
            fill_reg     <= '0;
            complete_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            fill_reg     <= fill_next;
            complete_reg <= complete_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg   <= func_next;
        char_reg   <= char_next;
        walk_reg   <= walk_next;
        ign_reg    <= ign_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

FILE: rtl/core/kscc_tables.sv
// ----------------------------------------------------------------------------
// kscc_tables
// Forward and inverse cipher tables with one shared append port and one
// registered lookup port.
// ----------------------------------------------------------------------------
module kscc_tables
    import kscc_pkg::*;
(
    input  logic    aclk,
    input  tbl_wr_t wr,
    input  tbl_rd_t rd,
    output idx_t    rd_data
);

    idx_t forward_mem [LETTERS];
    idx_t inverse_mem [LETTERS];

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            forward_mem[wr.pos]    <= wr.letter;
            inverse_mem[wr.letter] <= wr.pos;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data <= rd.inv ? inverse_mem[rd.addr] : forward_mem[rd.addr];
        end
    end

endmodule

FILE: rtl/core/kscc_checker.sv
// ----------------------------------------------------------------------------
// kscc_checker
// Port-level checks on the keyword substitution cipher core, bound to it.
// ----------------------------------------------------------------------------
`include "keyword_substitution_cipher_core_macros.svh"

module kscc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [0:0] m_tuser
);

    logic s_fire;
    logic char_ok;

    assign s_fire  = s_tvalid && s_tready;
    assign char_ok = (m_tdata == 8'd0) || (m_tdata == 8'd32) ||
                     ((m_tdata >= 8'd65) && (m_tdata <= 8'd90));

    `KSCC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    `KSCC_ASSERT_NEXT(a_busy_after_accept, s_fire, !s_tready, "second item taken while busy")

    `KSCC_ASSERT_SAME(a_ignored_is_key, m_tvalid && m_tuser[0], m_tdata == 8'd0, "ignored flag on a text result")

    `KSCC_ASSERT_SAME(a_char_range, m_tvalid, char_ok, "result character outside the alphabet")

endmodule

bind keyword_substitution_cipher_core kscc_checker u_kscc_checker (.*);
